FILE: rtl/wtosc_pkg.sv
package wtosc_pkg;

	localparam int TABLE_DEPTH_DEF     = 1024;
	localparam int PHASE_FRAC_BITS_DEF = 16;

	// item kinds carried on tuser
	localparam logic [1:0] OP_TICK     = 2'd0;
	localparam logic [1:0] OP_NOTE_ON  = 2'd1;
	localparam logic [1:0] OP_TABLE_WR = 2'd2;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_TABLE_LENGTH = 2'd0;
	localparam logic [1:0] REG_SUSTAIN_GAIN = 2'd1;
	localparam logic [1:0] REG_INVERSE_RATE = 2'd2;

	localparam logic [10:0] TABLE_LENGTH_RST = 11'd40;
	localparam logic [15:0] SUSTAIN_GAIN_RST = 16'd16384;
	localparam logic [31:0] INVERSE_RATE_RST = 32'd97392;

	typedef struct packed {
		logic accept;
		logic wr;
		logic note1;
		logic note2;
		logic note3;
		logic clr_sound;
		logic rd_a;
		logic rd_b;
		logic mul1;
		logic mul2;
		logic mul3;
		logic mod_load_phase;
		logic mod_step;
		logic out_load;
		logic out_zero;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic       env;
		logic       sounding;
		logic       phase_ge;
		logic       adv_big;
		logic       mod_last;
		logic       out_full;
	} dp_status_t;

	// note frequency in Q16.16 Hz: top octave value shifted down by octave
	function automatic logic [29:0] note_freq(input logic [6:0] note);
		logic [12:0] t;
		logic [3:0]  oct;
		logic [6:0]  base;
		logic [3:0]  semi;
		logic [29:0] top;
		t    = 13'(note) * 13'd43;
		oct  = t[12:9];
		base = 7'(oct) * 7'd12;
		semi = 4'(note - base);
		unique case (semi)
			4'd0:    top = 30'd548668578;
			4'd1:    top = 30'd581294110;
			4'd2:    top = 30'd615859657;
			4'd3:    top = 30'd652480578;
			4'd4:    top = 30'd691279089;
			4'd5:    top = 30'd732384684;
			4'd6:    top = 30'd775934542;
			4'd7:    top = 30'd822074016;
			4'd8:    top = 30'd870957076;
			4'd9:    top = 30'd922746880;
			4'd10:   top = 30'd977616267;
			4'd11:   top = 30'd1035748350;
			default: top = '0;
		endcase
		return top >> (4'd10 - oct);
	endfunction

endpackage

FILE: rtl/wtosc_ram.sv
module wtosc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: rtl/wtosc_ctrl.sv
module wtosc_ctrl import wtosc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       out_ready,
	input  dp_status_t st,
	output dp_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_WR,
		S_NOTE1,
		S_NOTE2,
		S_NOTE3,
		S_TICK,
		S_MOD,
		S_RDB,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_OUT
	} state_t;

	state_t state_q, state_d;
	logic   zero_q, zero_d;
	logic   post_q, post_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		zero_d  = zero_q;
		post_d  = post_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					unique case (st.opcode)
						OP_TICK:     state_d = S_TICK;
						OP_NOTE_ON:  state_d = S_NOTE1;
						OP_TABLE_WR: state_d = S_WR;
						default:     state_d = S_IDLE;
					endcase
				end
			end
			S_WR: begin
				cmd.wr  = 1'b1;
				state_d = S_IDLE;
			end
			S_NOTE1: begin
				cmd.note1 = 1'b1;
				state_d   = S_NOTE2;
			end
			S_NOTE2: begin
				cmd.note2 = 1'b1;
				state_d   = S_NOTE3;
			end
			S_NOTE3: begin
				cmd.note3 = 1'b1;
				state_d   = S_IDLE;
			end
			S_TICK: begin
				if (!st.env || !st.sounding) begin
					cmd.clr_sound = !st.env;
					zero_d        = 1'b1;
					state_d       = S_OUT;
				end else if (st.phase_ge) begin
					// table length shrank: reduce phase first
					cmd.mod_load_phase = 1'b1;
					post_d             = 1'b0;
					state_d            = S_MOD;
				end else begin
					cmd.rd_a = 1'b1;
					zero_d   = 1'b0;
					state_d  = S_RDB;
				end
			end
			S_RDB: begin
				cmd.rd_b = 1'b1;
				state_d  = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				post_d   = st.adv_big;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_MUL3;
			end
			S_MUL3: begin
				cmd.mul3 = 1'b1;
				state_d  = post_q ? S_MOD : S_OUT;
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (st.mod_last) begin
					state_d = post_q ? S_OUT : S_TICK;
				end
			end
			S_OUT: begin
				if (!st.out_full || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		cmd.out_zero = zero_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			zero_q  <= 1'b0;
			post_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			zero_q  <= zero_d;
			post_q  <= post_d;
		end
	end

endmodule

FILE: rtl/wtosc_dpath.sv
module wtosc_dpath import wtosc_pkg::*; #(
	parameter int TABLE_DEPTH     = TABLE_DEPTH_DEF,
	parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         opcode,
	input  logic [6:0]         note,
	input  logic [7:0]         velocity,
	input  logic [9:0]         table_addr,
	input  logic signed [15:0] table_data,
	input  logic               envelope_active,
	input  logic [10:0]        table_length,
	input  logic [15:0]        sustain_gain,
	input  logic [31:0]        inverse_rate,
	input  dp_cmd_t            cmd,
	output dp_status_t         st,
	input  logic               out_ready,
	output logic               out_valid,
	output logic signed [15:0] sample,
	output logic               voice_active
);

	localparam int F  = PHASE_FRAC_BITS;
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int LW = AW + 1;
	localparam int PW = AW + F;
	localparam int MW = PW + 1;
	localparam int CW = $clog2(MW + 1);
	localparam int TW = (LW > 11) ? LW : 11;

	localparam logic signed [F+17:0] RND1 = {{18{1'b0}}, 1'b1, {(F-1){1'b0}}};
	localparam logic signed [49:0]   RND3 = {{20{1'b0}}, 1'b1, {29{1'b0}}};

	// latched item fields
	logic [6:0]         note_q;
	logic [7:0]         vel_q;
	logic [9:0]         taddr_q;
	logic signed [15:0] tdata_q;
	logic               env_q;

	// voice state
	logic [PW-1:0] phase_q;
	logic [PW-1:0] step_q;
	logic [15:0]   amp_q;
	logic          sound_q;

	// note-on arithmetic
	logic [45:0]      p1_q;
	logic [31:0]      c_q;
	logic [29:0]      freq;
	logic [45:0]      hi_prod;
	logic [31+LW:0]   st_prod;
	logic [6:0]       vsat;
	logic [8:0]       rt;
	logic [15:0]      amp_c;

	// tick arithmetic
	logic [AW-1:0]           idx_q;
	logic [F-1:0]            w_q;
	logic signed [15:0]      a_q;
	logic signed [F+17:0]    prod1_s1;
	logic signed [32:0]      p2_s2;
	logic signed [49:0]      p3_s3;
	logic signed [16:0]      diff;
	logic signed [F:0]       wsg;
	logic signed [F+17:0]    prod1_d;
	logic signed [F+17:0]    sh;
	logic signed [15:0]      interp;
	logic signed [49:0]      sres;
	logic signed [15:0]      sat;

	// length and phase bookkeeping
	logic [TW-1:0]  tl;
	logic [LW-1:0]  len;
	logic [MW-1:0]  limit;
	logic [AW-1:0]  idx;
	logic [LW-1:0]  idx_inc;
	logic [AW-1:0]  nxt;
	logic [MW-1:0]  sum;
	logic [MW-1:0]  sub;

	// bit-serial remainder unit
	logic [MW-1:0] val_q;
	logic [MW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic [MW-1:0] rem_sh;
	logic [MW-1:0] rem_n;

	// table memory
	logic               ram_we;
	logic [AW-1:0]      ram_addr;
	logic signed [15:0] ram_rdata;
	logic               wr_ok;

	logic signed [15:0] out_sample_q;
	logic               out_active_q;
	logic               out_valid_q;

	assign tl = TW'(table_length);

	always_comb begin
		if (tl < TW'(2)) begin
			len = LW'(2);
		end else if (tl > TW'(TABLE_DEPTH)) begin
			len = LW'(TABLE_DEPTH);
		end else begin
			len = LW'(tl);
		end
	end

	assign limit   = {len, {F{1'b0}}};
	assign idx     = phase_q[PW-1:F];
	assign idx_inc = {1'b0, idx_q} + LW'(1);
	assign nxt     = (idx_inc >= len) ? '0 : idx_inc[AW-1:0];
	assign sum     = {1'b0, phase_q} + {1'b0, step_q};
	assign sub     = sum - limit;

	assign freq    = note_freq(note_q);
	assign hi_prod = freq * inverse_rate[31:16];
	assign st_prod = c_q * len;

	// amplitude = (v * 32768 + 63) / 127 = 258 v + (2 v + 63) / 127
	assign vsat  = vel_q[7] ? 7'd127 : vel_q[6:0];
	assign rt    = {1'b0, vsat, 1'b0} + 9'd63;
	assign amp_c = 16'(vsat) * 16'd258
		+ ((rt >= 9'd254) ? 16'd2 : (rt >= 9'd127) ? 16'd1 : 16'd0);

	assign diff    = {ram_rdata[15], ram_rdata} - {a_q[15], a_q};
	assign wsg     = $signed({1'b0, w_q});
	assign prod1_d = diff * wsg + RND1;
	assign sh      = prod1_s1 >>> F;
	assign interp  = a_q + 16'(sh);
	assign sres    = (p3_s3 + RND3) >>> 30;

	always_comb begin
		if (sres > 50'sd32767) begin
			sat = 16'sh7FFF;
		end else if (sres < -50'sd32768) begin
			sat = -16'sh8000;
		end else begin
			sat = 16'(sres);
		end
	end

	assign rem_sh = {rem_q[MW-2:0], val_q[MW-1]};
	assign rem_n  = (rem_sh >= limit) ? (rem_sh - limit) : rem_sh;

	assign wr_ok    = (32'(taddr_q) < 32'(TABLE_DEPTH));
	assign ram_we   = cmd.wr && wr_ok;
	assign ram_addr = cmd.wr ? AW'(taddr_q) : (cmd.rd_b ? nxt : idx);

	wtosc_ram #(
		.WIDTH (16),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (tdata_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			note_q  <= note;
			vel_q   <= velocity;
			taddr_q <= table_addr;
			tdata_q <= table_data;
			env_q   <= envelope_active;
		end
		if (cmd.note1) begin
			p1_q <= freq * inverse_rate[15:0];
		end
		if (cmd.note2) begin
			c_q <= hi_prod[31:0] + {2'b00, p1_q[45:16]};
		end
		if (cmd.rd_a) begin
			idx_q <= idx;
			w_q   <= phase_q[F-1:0];
		end
		if (cmd.rd_b) begin
			a_q <= ram_rdata;
		end
		if (cmd.mul1) begin
			prod1_s1 <= prod1_d;
		end
		if (cmd.mul2) begin
			p2_s2 <= interp * $signed({1'b0, amp_q});
		end
		if (cmd.mul3) begin
			p3_s3 <= p2_s2 * $signed({1'b0, sustain_gain});
		end
		if (cmd.out_load) begin
			out_sample_q <= cmd.out_zero ? '0 : sat;
			out_active_q <= !cmd.out_zero;
		end
		if (cmd.mod_load_phase) begin
			val_q <= {1'b0, phase_q};
			rem_q <= '0;
		end else if (cmd.mul1 && (sum >= limit) && (sub >= limit)) begin
			val_q <= sum;
			rem_q <= '0;
		end else if (cmd.mod_step) begin
			val_q <= val_q << 1;
			rem_q <= rem_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			step_q      <= '0;
			amp_q       <= '0;
			sound_q     <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.note3) begin
				step_q  <= st_prod[32-F +: PW];
				amp_q   <= amp_c;
				phase_q <= '0;
				sound_q <= 1'b1;
			end
			if (cmd.clr_sound) begin
				sound_q <= 1'b0;
			end
			if (cmd.mul1) begin
				if (sum < limit) begin
					phase_q <= PW'(sum);
				end else if (sub < limit) begin
					phase_q <= PW'(sub);
				end
			end
			if (cmd.mod_load_phase || (cmd.mul1 && (sum >= limit) && (sub >= limit))) begin
				cnt_q <= CW'(MW);
			end else if (cmd.mod_step) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					phase_q <= PW'(rem_n);
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign st.opcode   = opcode;
	assign st.env      = env_q;
	assign st.sounding = sound_q;
	assign st.phase_ge = ({1'b0, phase_q} >= limit);
	assign st.adv_big  = (sum >= limit) && (sub >= limit);
	assign st.mod_last = (cnt_q == CW'(1));
	assign st.out_full = out_valid_q;

	assign out_valid    = out_valid_q;
	assign sample       = out_sample_q;
	assign voice_active = out_active_q;

endmodule

FILE: rtl/wavetable_oscillator_interp_unit.sv
// Tick: two single-port table reads and three multiply stages; a tick also waits while the
// previous result is not taken. No new item is accepted before the last one is done. After
// table_length was lowered, or if phase plus step reaches twice the length, a tick also
// runs the bit-serial phase remainder unit, W = clog2(TABLE_DEPTH) + PHASE_FRAC_BITS + 1 bits
// wide (27 at defaults). Note-on: NOTE1..NOTE3; a silent tick skips reads and multiplies.
// Reset (arst_n low, async): voice silent, phase/step/amplitude zero, registers at defaults.
module wavetable_oscillator_interp_unit import wtosc_pkg::*; #(
	parameter int TABLE_DEPTH     = TABLE_DEPTH_DEF,
	parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// note[6:0], velocity[14:7], table_addr[24:15], table_data[40:25], envelope_active[41]
	input  logic [47:0] s_axis_tdata,
	// opcode[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// sample[15:0], voice_active[16]
	output logic [23:0] m_axis_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [10:0] table_length_q;
	logic [15:0] sustain_gain_q;
	logic [31:0] inverse_rate_q;

	dp_cmd_t    cmd;
	dp_status_t st;

	logic signed [15:0] sample;
	logic               voice_active;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q <= TABLE_LENGTH_RST;
			sustain_gain_q <= SUSTAIN_GAIN_RST;
			inverse_rate_q <= INVERSE_RATE_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_TABLE_LENGTH: table_length_q <= pwdata[10:0];
				REG_SUSTAIN_GAIN: sustain_gain_q <= pwdata[15:0];
				REG_INVERSE_RATE: inverse_rate_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_TABLE_LENGTH: prdata = {21'd0, table_length_q};
			REG_SUSTAIN_GAIN: prdata = {16'd0, sustain_gain_q};
			REG_INVERSE_RATE: prdata = inverse_rate_q;
			default:          prdata = '0;
		endcase
	end

	wtosc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_ready (m_axis_tready),
		.st        (st),
		.cmd       (cmd)
	);

	wtosc_dpath #(
		.TABLE_DEPTH     (TABLE_DEPTH),
		.PHASE_FRAC_BITS (PHASE_FRAC_BITS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.opcode          (s_axis_tuser),
		.note            (s_axis_tdata[6:0]),
		.velocity        (s_axis_tdata[14:7]),
		.table_addr      (s_axis_tdata[24:15]),
		.table_data      (s_axis_tdata[40:25]),
		.envelope_active (s_axis_tdata[41]),
		.table_length    (table_length_q),
		.sustain_gain    (sustain_gain_q),
		.inverse_rate    (inverse_rate_q),
		.cmd             (cmd),
		.st              (st),
		.out_ready       (m_axis_tready),
		.out_valid       (m_axis_tvalid),
		.sample          (sample),
		.voice_active    (voice_active)
	);

	assign m_axis_tdata = {7'd0, voice_active, sample};

endmodule

FILE: test/testbench.sv
module testbench;
	import wtosc_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int SETTLE_CYCLES  = 80;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct packed {
		logic [1:0]  op;
		logic [6:0]  note;
		logic [7:0]  vel;
		logic [9:0]  addr;
		logic [15:0] data;
		logic        env;
	} voice_cmd_t;

	typedef struct packed {
		logic signed [15:0] smp;
		logic               act;
	} voice_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// note[6:0], velocity[14:7], table_addr[24:15], table_data[40:25], envelope_active[41]
	logic [47:0] s_axis_tdata = '0;
	// opcode[1:0]
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// sample[15:0], voice_active[16]
	logic [23:0] m_axis_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	wavetable_oscillator_interp_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// register mirror
	logic [10:0] cfg_len  = TABLE_LENGTH_RST;
	logic [15:0] cfg_gain = SUSTAIN_GAIN_RST;
	logic [31:0] cfg_inv  = INVERSE_RATE_RST;

	// voice state as seen by the block
	logic signed [15:0] wave_mem [1024];
	logic [25:0] osc_phase = '0;
	logic [25:0] osc_step = '0;
	logic [15:0] osc_amp = '0;
	logic        osc_on = 1'b0;
	voice_out_t  samples_due [$];

	// voice state tracked while items are queued, to keep table reads on loaded entries
	logic        loaded [1024];
	logic [25:0] plan_phase = '0;
	logic [25:0] plan_step = '0;
	logic        plan_on = 1'b0;
	voice_cmd_t  voice_cmds [$];

	int gap_pct = 0;
	int hold_asked = 0;
	int err_cnt = 0;

	initial foreach (loaded[i]) loaded[i] = 1'b0;

	function automatic longint unsigned eff_len(input logic [10:0] l);
		if (l < 11'd2) return 2;
		if (l > 11'd1024) return 1024;
		return longint'(l);
	endfunction

	function automatic logic [29:0] top_octave(input logic [3:0] semi);
		case (semi)
			4'd0:    return 30'd548668578;
			4'd1:    return 30'd581294110;
			4'd2:    return 30'd615859657;
			4'd3:    return 30'd652480578;
			4'd4:    return 30'd691279089;
			4'd5:    return 30'd732384684;
			4'd6:    return 30'd775934542;
			4'd7:    return 30'd822074016;
			4'd8:    return 30'd870957076;
			4'd9:    return 30'd922746880;
			4'd10:   return 30'd977616267;
			default: return 30'd1035748350;
		endcase
	endfunction

	function automatic logic [25:0] note_step(input logic [6:0] n);
		longint unsigned f, c, st, len;
		len = eff_len(cfg_len);
		f   = longint'(top_octave(4'(n % 12))) >> (10 - n / 12);
		c   = (f * longint'(cfg_inv)) >> 16;
		st  = (c * len) >> 16;
		return 26'(st % (len << 16));
	endfunction

	function automatic logic [15:0] vel_amp(input logic [7:0] v);
		int unsigned vs;
		vs = (v > 8'd127) ? 127 : v;
		return 16'((vs * 32768 + 63) / 127);
	endfunction

	function automatic logic [47:0] pack_fields(input voice_cmd_t c);
		return {6'b0, c.env, c.data, c.addr, c.vel, c.note};
	endfunction

	function automatic voice_cmd_t random_cmd(input logic [1:0] op);
		voice_cmd_t c;
		c = voice_cmd_t'(44'({$urandom(), $urandom()}));
		c.op = op;
		return c;
	endfunction

	task automatic oscillate(input voice_cmd_t c);
		longint unsigned len, lim, p, idx, nxt, w;
		longint a, b, interp, prod, s;
		voice_out_t r;
		len = eff_len(cfg_len);
		lim = len << 16;
		case (c.op)
			OP_NOTE_ON: begin
				osc_step  = note_step(c.note);
				osc_amp   = vel_amp(c.vel);
				osc_phase = '0;
				osc_on    = 1'b1;
			end
			OP_TABLE_WR: wave_mem[c.addr] = c.data;
			OP_TICK: begin
				if (!c.env)
					osc_on = 1'b0;
				r = '0;
				if (osc_on) begin
					p   = longint'(osc_phase) % lim;
					idx = p >> 16;
					w   = p & 64'hFFFF;
					nxt = idx + 1;
					if (nxt >= len)
						nxt = 0;
					a      = wave_mem[idx];
					b      = wave_mem[nxt];
					interp = a + (((b - a) * longint'(w) + 32768) >>> 16);
					prod   = interp * longint'(osc_amp) * longint'(cfg_gain);
					s      = (prod + (64'sd1 <<< 29)) >>> 30;
					if (s > 32767)
						s = 32767;
					if (s < -32768)
						s = -32768;
					r.smp     = 16'(s);
					r.act     = 1'b1;
					osc_phase = 26'((p + longint'(osc_step)) % lim);
				end
				samples_due.push_back(r);
			end
			default: ;
		endcase
	endtask

	task automatic load_entry(input longint unsigned idx);
		voice_cmd_t w;
		w = random_cmd(OP_TABLE_WR);
		w.addr = 10'(idx);
		loaded[idx] = 1'b1;
		voice_cmds.push_back(w);
	endtask

	task automatic queue_item(input voice_cmd_t c);
		longint unsigned len, lim, p, idx, nxt;
		len = eff_len(cfg_len);
		lim = len << 16;
		case (c.op)
			OP_NOTE_ON: begin
				plan_step  = note_step(c.note);
				plan_phase = '0;
				plan_on    = 1'b1;
			end
			OP_TABLE_WR: loaded[c.addr] = 1'b1;
			OP_TICK: begin
				if (!c.env)
					plan_on = 1'b0;
				if (plan_on) begin
					p   = longint'(plan_phase) % lim;
					idx = p >> 16;
					nxt = idx + 1;
					if (nxt >= len)
						nxt = 0;
					if (!loaded[idx])
						load_entry(idx);
					if (!loaded[nxt])
						load_entry(nxt);
					plan_phase = 26'((p + longint'(plan_step)) % lim);
				end
			end
			default: ;
		endcase
		voice_cmds.push_back(c);
	endtask

	task automatic directed(input logic [1:0] op, input logic [6:0] note,
			input logic [7:0] vel, input logic [9:0] addr, input logic [15:0] data,
			input logic env);
		voice_cmd_t c;
		c = '{op: op, note: note, vel: vel, addr: addr, data: data, env: env};
		queue_item(c);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_TABLE_LENGTH: cfg_len  = val[10:0];
			REG_SUSTAIN_GAIN: cfg_gain = val[15:0];
			REG_INVERSE_RATE: cfg_inv  = val;
			default: ;
		endcase
	endtask

	task automatic settle();
		while (voice_cmds.size() != 0 || s_axis_tvalid || samples_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [10:0] len, input logic [15:0] gain,
			input logic [31:0] inv, input int gaps, input bit hold, input int n);
		voice_cmd_t c;
		int r;
		settle();
		reg_write(REG_TABLE_LENGTH, 32'(len));
		reg_write(REG_SUSTAIN_GAIN, 32'(gain));
		reg_write(REG_INVERSE_RATE, inv);
		gap_pct = gaps;
		if (hold)
			hold_asked++;
		// ticks before any note-on: voice left over from the previous setting
		repeat (3) begin
			c = random_cmd(OP_TICK);
			c.env = 1'b1;
			queue_item(c);
		end
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			c = random_cmd(OP_TICK);
			if (r < 8)
				c.op = OP_NOTE_ON;
			else if (r < 26)
				c.op = OP_TABLE_WR;
			else if (r < 29)
				c.op = OP_NONE;
			else
				c.env = ($urandom_range(99) >= 5);
			queue_item(c);
		end
	endtask

	// sender
	voice_cmd_t on_wire;
	int         send_gap = 0;

	always @(posedge clk or negedge arst_n) begin
		logic send;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
			send_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				oscillate(on_wire);
			if (!s_axis_tvalid || s_axis_tready) begin
				send = 1'b0;
				if (send_gap == 0 && voice_cmds.size() != 0 && $urandom_range(99) < gap_pct)
					send_gap = $urandom_range(4, 1);
				if (send_gap != 0) begin
					send_gap--;
				end else if (voice_cmds.size() != 0) begin
					on_wire = voice_cmds.pop_front();
					send = 1'b1;
					s_axis_tdata <= pack_fields(on_wire);
					s_axis_tuser <= on_wire.op;
				end
				s_axis_tvalid <= send;
			end
		end
	end

	// receiver
	int hold_served = 0;
	int hold_left = 0;
	int stall_left = 0;

	always @(posedge clk or negedge arst_n) begin
		voice_out_t want;
		logic rdy;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left = 0;
			stall_left = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (samples_due.size() == 0) begin
					$error("unexpected item: sample %0d, voice_active %0b",
						$signed(m_axis_tdata[15:0]), m_axis_tdata[16]);
					err_cnt++;
				end else begin
					want = samples_due.pop_front();
					if (m_axis_tdata[15:0] !== want.smp) begin
						$error("sample: expected %0d, got %0d", want.smp,
							$signed(m_axis_tdata[15:0]));
						err_cnt++;
					end
					if (m_axis_tdata[16] !== want.act) begin
						$error("voice_active: expected %0b, got %0b", want.act,
							m_axis_tdata[16]);
						err_cnt++;
					end
				end
			end
			if (hold_served != hold_asked) begin
				hold_served = hold_asked;
				hold_left = HOLD_CYCLES;
			end
			rdy = 1'b0;
			if (hold_left != 0)
				hold_left--;
			else if (stall_left != 0)
				stall_left--;
			else if ($urandom_range(99) < gap_pct)
				stall_left = $urandom_range(4, 1) - 1;
			else
				rdy = 1'b1;
			m_axis_tready <= rdy;
		end
	end

	// watchdog
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset register values
		gap_pct = 30;
		directed(OP_TICK, 7'd5, 8'd0, 10'd0, 16'h0000, 1'b1);
		directed(OP_TICK, 7'd0, 8'd0, 10'd0, 16'h0000, 1'b0);
		directed(OP_NONE, 7'h7F, 8'hFF, 10'h3FF, 16'hFFFF, 1'b1);
		directed(OP_TABLE_WR, 7'd0, 8'd0, 10'd0, 16'h8000, 1'b0);
		directed(OP_TABLE_WR, 7'd0, 8'd0, 10'd1023, 16'h7FFF, 1'b0);
		directed(OP_TABLE_WR, 7'd0, 8'd0, 10'd39, 16'h7FFF, 1'b0);
		directed(OP_NOTE_ON, 7'd0, 8'd0, 10'd0, 16'h0000, 1'b0);
		directed(OP_TICK, 7'd0, 8'd0, 10'd0, 16'h0000, 1'b1);
		directed(OP_TICK, 7'd0, 8'd0, 10'd0, 16'h0000, 1'b1);
		directed(OP_NOTE_ON, 7'd127, 8'd255, 10'd0, 16'h0000, 1'b0);
		repeat (4) directed(OP_TICK, 7'd0, 8'd0, 10'd0, 16'h0000, 1'b1);
		directed(OP_NOTE_ON, 7'd69, 8'd127, 10'd0, 16'h0000, 1'b0);
		repeat (3) directed(OP_TICK, 7'd0, 8'd0, 10'd0, 16'h0000, 1'b1);
		directed(OP_TICK, 7'd0, 8'd0, 10'd0, 16'h0000, 1'b0);
		directed(OP_TICK, 7'd0, 8'd0, 10'd0, 16'h0000, 1'b1);
		directed(OP_NOTE_ON, 7'd60, 8'd128, 10'd0, 16'h0000, 1'b0);
		directed(OP_TICK, 7'd0, 8'd0, 10'd0, 16'h0000, 1'b1);

		run_phase(11'd2, 16'd32768, 32'd1, 20, 1'b0, 100);
		run_phase(11'd1024, 16'd0, 32'hFFFF_FFFF, 40, 1'b0, 100);
		run_phase(11'd1024, 16'd32768, 32'd97392, 10, 1'b1, 100);
		// shorter table while the voice may still sound
		run_phase(11'd37, 16'($urandom_range(32768)), $urandom_range(32'hFFFF_FFFF, 1),
			30, 1'b0, 100);
		run_phase(11'd3, 16'd32768, 32'hFFFF_FFFF, 0, 1'b0, 100);
		run_phase(11'($urandom_range(1024, 2)), 16'($urandom_range(32768)),
			$urandom_range(32'hFFFF_FFFF, 1), 25, 1'b0, 100);
		run_phase(TABLE_LENGTH_RST, SUSTAIN_GAIN_RST, INVERSE_RATE_RST, 0, 1'b0, 100);

		settle();
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: files.f
rtl/wtosc_pkg.sv
rtl/wtosc_ram.sv
rtl/wtosc_ctrl.sv
rtl/wtosc_dpath.sv
rtl/wavetable_oscillator_interp_unit.sv
test/testbench.sv
